### rtl/ssg_pkg.sv
// Shared constants and types for the spindle-synced step generator.
`default_nettype none

package ssg_pkg;

    // Default sizes of the encoder count and of the feed ratio fraction.
    localparam int SSG_COUNT_BITS      = 24;
    localparam int SSG_RATIO_FRAC_BITS = 24;
    // Integer bits of the feed ratio (Q4.x format).
    localparam int SSG_RATIO_INT_BITS  = 4;
    // Width of the position words.
    localparam int SSG_POS_BITS        = 32;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FEED_RATIO      = 2'd0,
        CFG_FEED_REVERSE    = 2'd1,
        CFG_DRIVE_ENABLE    = 2'd2,
        CFG_ENCODER_MODULUS = 2'd3
    } cfg_index_t;

    // Step/direction pin state: bit 1 is the step pin, bit 0 the direction pin.
    typedef enum logic [1:0] {
        PIN_IDLE     = 2'b00,
        PIN_DIR      = 2'b01,
        PIN_STEP_REV = 2'b10,
        PIN_STEP_FWD = 2'b11
    } pin_state_t;

endpackage

`default_nettype wire

### rtl/ssg_if.sv
// Channel interfaces of the step generator: encoder samples, results and configuration.
`default_nettype none

// Encoder sample channel.
interface ssg_sample_if
    import ssg_pkg::*;
#(
    parameter int COUNT_BITS = SSG_COUNT_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] encoder_count;

    modport source (output valid, output encoder_count, input ready);
    modport sink   (input valid, input encoder_count, output ready);
endinterface

// Result channel: pin levels and positions after one tick.
interface ssg_result_if
    import ssg_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic                           step_level;
    logic                           dir_level;
    logic signed [SSG_POS_BITS-1:0] target_position;
    logic signed [SSG_POS_BITS-1:0] motor_position;

    modport source (output valid, output step_level, output dir_level,
                    output target_position, output motor_position, input ready);
    modport sink   (input valid, input step_level, input dir_level,
                    input target_position, input motor_position, output ready);
endinterface

// Configuration write channel.
interface ssg_cfg_if
    import ssg_pkg::*;
#(
    parameter int DATA_BITS = SSG_RATIO_FRAC_BITS + SSG_RATIO_INT_BITS
);
    logic                 valid;
    logic                 ready;
    cfg_index_t           index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/spindle_synced_step_generator.sv
// Spindle-synced step/direction generator. Each encoder sample transfer yields
// exactly one result transfer, in order. The block takes one sample per clock
// unless the result channel stalls it; a sample passes an input register, the
// count-times-ratio multiplier register, the scaling and saturation register,
// and the tracking stage whose registers drive the result channel. The tracking
// stage (tracked position and pin state) and the count history close their
// loops in their own registers, so back-to-back samples run at full rate. The
// wrap correction term is computed from the configuration registers via the
// modulus product and wrap term registers. The step machine moves the motor by
// at most one step every two samples. There is no clearing pass after reset.
`default_nettype none

module spindle_synced_step_generator
    import ssg_pkg::*;
#(
    parameter int COUNT_BITS      = SSG_COUNT_BITS,
    parameter int RATIO_FRAC_BITS = SSG_RATIO_FRAC_BITS
)
(
    input  wire         clk,
    input  wire         rst_n,
    ssg_sample_if.sink  sample,
    ssg_result_if.source result,
    ssg_cfg_if.sink     cfg
);

    localparam int RATIO_BITS = RATIO_FRAC_BITS + SSG_RATIO_INT_BITS;
    localparam int MOD_BITS   = COUNT_BITS + 1;
    localparam int PROD_BITS  = MOD_BITS + RATIO_BITS;
    localparam int MAG_BITS   = PROD_BITS - RATIO_FRAC_BITS;
    localparam int SAT_BITS   = (MAG_BITS > SSG_POS_BITS + 1) ? MAG_BITS : SSG_POS_BITS + 1;

    localparam logic [SAT_BITS-1:0] POS_LIMIT = SAT_BITS'({1'b0, {(SSG_POS_BITS-1){1'b1}}});
    localparam logic [SAT_BITS-1:0] NEG_LIMIT = SAT_BITS'({1'b1, {(SSG_POS_BITS-1){1'b0}}});
    localparam logic [RATIO_BITS-1:0] RATIO_ONE  = RATIO_BITS'(1) << RATIO_FRAC_BITS;
    localparam logic [MOD_BITS-1:0]   MOD_RESET  = MOD_BITS'(1) << COUNT_BITS;

    // Truncated product scaled to steps, negated when reversed, saturated to 32 bits.
    function automatic logic [SSG_POS_BITS-1:0] scale_steps(
        input logic [PROD_BITS-1:0] prod,
        input logic                 rev
    );
        logic [SAT_BITS-1:0]     mag;
        logic [SSG_POS_BITS-1:0] low;
        mag = SAT_BITS'(prod[PROD_BITS-1:RATIO_FRAC_BITS]);
        if (rev)
        begin
            if (mag > NEG_LIMIT)
            begin
                mag = NEG_LIMIT;
            end
            low = mag[SSG_POS_BITS-1:0];
            return SSG_POS_BITS'(0) - low;
        end
        if (mag > POS_LIMIT)
        begin
            mag = POS_LIMIT;
        end
        return mag[SSG_POS_BITS-1:0];
    endfunction

    // Configuration registers.
    logic [RATIO_BITS-1:0] feed_ratio_reg;
    logic                  feed_reverse_reg;
    logic                  drive_enable_reg;
    logic [MOD_BITS-1:0]   encoder_modulus_reg;

    // Wrap correction term, derived from configuration.
    logic [PROD_BITS-1:0]    mod_prod_reg;
    logic [SSG_POS_BITS-1:0] mod_term_reg;

    // Pipeline valid bits and payload.
    logic                    s1_valid_reg;
    logic [COUNT_BITS-1:0]   s1_count_reg;
    logic                    s2_valid_reg;
    logic [PROD_BITS-1:0]    s2_prod_reg;
    logic                    s2_wrap_up_reg;
    logic                    s2_wrap_dn_reg;
    logic                    s2_resync_reg;
    logic                    s3_valid_reg;
    logic [SSG_POS_BITS-1:0] s3_target_reg;
    logic                    s3_wrap_up_reg;
    logic                    s3_wrap_dn_reg;
    logic                    s3_resync_reg;
    logic                    out_valid_reg;
    logic [SSG_POS_BITS-1:0] out_target_reg;

    // Tracking state.
    logic [COUNT_BITS-1:0]   last_count_reg;
    logic [RATIO_BITS-1:0]   last_ratio_reg;
    logic                    last_reverse_reg;
    logic [SSG_POS_BITS-1:0] tracked_reg;
    logic [SSG_POS_BITS-1:0] tracked_next;
    pin_state_t              pin_reg;
    pin_state_t              pin_next;

    logic                    free1;
    logic                    free2;
    logic                    free3;
    logic                    free4;
    logic [PROD_BITS-1:0]    prod_next;
    logic [COUNT_BITS-1:0]   half_mod;
    logic                    wrap_up_next;
    logic                    wrap_dn_next;
    logic [SSG_POS_BITS-1:0] base_pos;
    logic                    target_below;
    logic                    target_above;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_ratio_reg      <= RATIO_ONE;
            feed_reverse_reg    <= 1'b0;
            drive_enable_reg    <= 1'b1;
            encoder_modulus_reg <= MOD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FEED_RATIO:      feed_ratio_reg      <= cfg.data[RATIO_BITS-1:0];
                CFG_FEED_REVERSE:    feed_reverse_reg    <= cfg.data[0];
                CFG_DRIVE_ENABLE:    drive_enable_reg    <= cfg.data[0];
                CFG_ENCODER_MODULUS: encoder_modulus_reg <= cfg.data[MOD_BITS-1:0];
                default:             feed_ratio_reg      <= feed_ratio_reg;
            endcase
        end
    end

    // Modulus times ratio, registered, then scaled into the wrap term register.
    always_ff @(posedge clk)
    begin
        mod_prod_reg <= encoder_modulus_reg * feed_ratio_reg;
        mod_term_reg <= scale_steps(mod_prod_reg, feed_reverse_reg);
    end

    // A stage loads when it is empty or its content moves on.
    assign free4        = !out_valid_reg || result.ready;
    assign free3        = !s3_valid_reg || free4;
    assign free2        = !s2_valid_reg || free3;
    assign free1        = !s1_valid_reg || free2;
    assign sample.ready = free1;

    // Stage 2 inputs: product and wrap detection against the previous count.
    assign prod_next    = {1'b0, s1_count_reg} * feed_ratio_reg;
    assign half_mod     = encoder_modulus_reg[MOD_BITS-1:1];
    assign wrap_dn_next = (s1_count_reg < last_count_reg)
                       && ((last_count_reg - s1_count_reg) > half_mod);
    assign wrap_up_next = (s1_count_reg > last_count_reg)
                       && ((s1_count_reg - last_count_reg) > half_mod);

    // Valid bits and history state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_count_reg   <= '0;
            last_ratio_reg   <= '0;
            last_reverse_reg <= 1'b0;
            tracked_reg      <= '0;
            pin_reg          <= PIN_IDLE;
        end
        else
        begin
            if (free1)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (free2)
            begin
                s2_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    last_count_reg   <= s1_count_reg;
                    last_ratio_reg   <= feed_ratio_reg;
                    last_reverse_reg <= feed_reverse_reg;
                end
            end
            if (free3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (free4)
            begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg)
                begin
                    tracked_reg <= tracked_next;
                    pin_reg     <= pin_next;
                end
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (free1 && sample.valid)
        begin
            s1_count_reg <= sample.encoder_count;
        end
        if (free2 && s1_valid_reg)
        begin
            s2_prod_reg    <= prod_next;
            s2_wrap_up_reg <= wrap_up_next;
            s2_wrap_dn_reg <= wrap_dn_next;
            s2_resync_reg  <= (feed_ratio_reg != last_ratio_reg)
                           || (feed_reverse_reg != last_reverse_reg);
        end
        if (free3 && s2_valid_reg)
        begin
            s3_target_reg  <= scale_steps(s2_prod_reg, feed_reverse_reg);
            s3_wrap_up_reg <= s2_wrap_up_reg;
            s3_wrap_dn_reg <= s2_wrap_dn_reg;
            s3_resync_reg  <= s2_resync_reg;
        end
        if (free4 && s3_valid_reg)
        begin
            out_target_reg <= s3_target_reg;
        end
    end

    // Position after wrap correction or resynchronization.
    always_comb
    begin
        if (s3_resync_reg)
        begin
            base_pos = s3_target_reg;
        end
        else if (s3_wrap_up_reg)
        begin
            base_pos = tracked_reg + mod_term_reg;
        end
        else if (s3_wrap_dn_reg)
        begin
            base_pos = tracked_reg - mod_term_reg;
        end
        else
        begin
            base_pos = tracked_reg;
        end
    end

    assign target_below = $signed(s3_target_reg) < $signed(base_pos);
    assign target_above = $signed(base_pos) < $signed(s3_target_reg);

    // Step/direction machine.
    always_comb
    begin
        tracked_next = base_pos;
        pin_next     = pin_reg;
        if (!drive_enable_reg)
        begin
            tracked_next = s3_target_reg;
        end
        else
        begin
            case (pin_reg)
                PIN_IDLE:
                begin
                    if (target_below)
                    begin
                        pin_next = PIN_STEP_REV;
                    end
                    else if (target_above)
                    begin
                        pin_next = PIN_DIR;
                    end
                end
                PIN_DIR:
                begin
                    if (target_above)
                    begin
                        pin_next = PIN_STEP_FWD;
                    end
                    else if (target_below)
                    begin
                        pin_next = PIN_IDLE;
                    end
                end
                PIN_STEP_REV:
                begin
                    tracked_next = base_pos - SSG_POS_BITS'(1);
                    pin_next     = PIN_IDLE;
                end
                PIN_STEP_FWD:
                begin
                    tracked_next = base_pos + SSG_POS_BITS'(1);
                    pin_next     = PIN_DIR;
                end
                default:
                begin
                    pin_next = PIN_IDLE;
                end
            endcase
        end
    end

    // The tracking registers are the result register.
    assign result.valid           = out_valid_reg;
    assign result.step_level      = pin_reg[1];
    assign result.dir_level       = pin_reg[0];
    assign result.target_position = $signed(out_target_reg);
    assign result.motor_position  = $signed(tracked_reg);

endmodule

`default_nettype wire

### verif/step_gen_checker.sv
// Checker for the step generator: predicts each result from the sample and config transfers.
`timescale 1ns / 100ps

module step_gen_checker
    import ssg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssg_sample_if       sample,
    ssg_result_if       result,
    ssg_cfg_if          cfg,
    output int unsigned outstanding,
    output int unsigned errors
);

    // One predicted result transfer.
    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic [31:0] target_position;
        logic [31:0] motor_position;
    } tick_result_t;

    // Shadow of the configuration registers.
    logic [27:0] ratio_q;
    logic        reverse_q;
    logic        enable_q;
    logic [24:0] modulus_q;

    // Predicted tracking state.
    logic [31:0] motor_q;
    logic [23:0] prev_count;
    pin_state_t  pins;
    logic [27:0] prev_ratio;
    logic        prev_reverse;

    tick_result_t expected_ticks[$];

    // Count times feed ratio, truncated, signed by direction and saturated to 32 bits.
    function automatic logic [31:0] feed_steps(input logic [24:0] cnt);
        logic [63:0] mag;
        mag = (64'(cnt) * 64'(ratio_q)) >> SSG_RATIO_FRAC_BITS;
        if (reverse_q)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'd0 - mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Advances the predicted state by one encoder sample and returns the result it causes.
    function automatic tick_result_t advance_tick(input logic [23:0] cnt);
        logic [31:0]  target;
        logic [24:0]  half;
        tick_result_t res;
        target = feed_steps({1'b0, cnt});
        half   = modulus_q >> 1;

        // A jump of more than half the modulus is taken as an encoder wrap.
        if (cnt < prev_count && 25'(prev_count - cnt) > half)
            motor_q = motor_q - feed_steps(modulus_q);
        if (cnt > prev_count && 25'(cnt - prev_count) > half)
            motor_q = motor_q + feed_steps(modulus_q);

        // A change of ratio or direction resynchronizes the motor to the target.
        if (ratio_q != prev_ratio || reverse_q != prev_reverse)
            motor_q = target;

        prev_count   = cnt;
        prev_ratio   = ratio_q;
        prev_reverse = reverse_q;

        // Step/direction machine, or plain tracking when the drive is off.
        if (enable_q)
        begin
            case (pins)
                PIN_IDLE:
                begin
                    if ($signed(target) < $signed(motor_q))
                        pins = PIN_STEP_REV;
                    else if ($signed(motor_q) < $signed(target))
                        pins = PIN_DIR;
                end
                PIN_DIR:
                begin
                    if ($signed(motor_q) < $signed(target))
                        pins = PIN_STEP_FWD;
                    else if ($signed(target) < $signed(motor_q))
                        pins = PIN_IDLE;
                end
                PIN_STEP_REV:
                begin
                    motor_q = motor_q - 32'd1;
                    pins    = PIN_IDLE;
                end
                default:
                begin
                    motor_q = motor_q + 32'd1;
                    pins    = PIN_DIR;
                end
            endcase
        end
        else
        begin
            motor_q = target;
        end

        res.step_level      = pins[1];
        res.dir_level       = pins[0];
        res.target_position = target;
        res.motor_position  = motor_q;
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors = errors + 1;
    endtask

    // Watch all three channels; results are compared against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            ratio_q      = 28'h100_0000;
            reverse_q    = 1'b0;
            enable_q     = 1'b1;
            modulus_q    = 25'h100_0000;
            motor_q      = '0;
            prev_count   = '0;
            pins         = PIN_IDLE;
            prev_ratio   = '0;
            prev_reverse = 1'b0;
            errors       = 0;
            expected_ticks.delete();
            outstanding <= 0;
        end
        else
        begin
            // Register write transfer.
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FEED_RATIO:      ratio_q   = cfg.data[27:0];
                    CFG_FEED_REVERSE:    reverse_q = cfg.data[0];
                    CFG_DRIVE_ENABLE:    enable_q  = cfg.data[0];
                    CFG_ENCODER_MODULUS: modulus_q = cfg.data[24:0];
                    default: ;
                endcase
            end

            // Result transfer.
            if (result.valid && result.ready)
            begin
                if (expected_ticks.size() == 0)
                begin
                    report_mismatch("result transfer with no prediction pending");
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (result.step_level !== want.step_level)
                        report_mismatch($sformatf("step_level got %0b expected %0b",
                                                  result.step_level, want.step_level));
                    if (result.dir_level !== want.dir_level)
                        report_mismatch($sformatf("dir_level got %0b expected %0b",
                                                  result.dir_level, want.dir_level));
                    if (result.target_position !== want.target_position)
                        report_mismatch($sformatf("target_position got %0d expected %0d",
                                                  result.target_position,
                                                  $signed(want.target_position)));
                    if (result.motor_position !== want.motor_position)
                        report_mismatch($sformatf("motor_position got %0d expected %0d",
                                                  result.motor_position,
                                                  $signed(want.motor_position)));
                end
            end

            // Sample transfer.
            if (sample.valid && sample.ready)
                expected_ticks.push_back(advance_tick(sample.encoder_count));

            outstanding <= expected_ticks.size();
        end
    end

endmodule

### verif/spindle_synced_step_generator_tb.sv
// Testbench top for the step generator: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module spindle_synced_step_generator_tb;
    import ssg_pkg::*;

    localparam logic [27:0] RATIO_ONE    = 28'h100_0000;
    localparam logic [27:0] RATIO_MAX    = 28'hFFF_FFFF;
    localparam logic [24:0] MOD_FULL     = 25'h100_0000;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          DRAIN_CYCLES = 12;

    // Shapes of encoder count sequences.
    typedef enum int {
        SEQ_WALK_FWD,
        SEQ_WALK_BACK,
        SEQ_RATCHET_UP,
        SEQ_RATCHET_DOWN,
        SEQ_NOISE
    } seq_kind_t;

    logic        clk;
    logic        rst_n;
    int unsigned outstanding;
    int unsigned errors;

    // Current settings and sequence state, used to shape the counts.
    logic [27:0] ratio_now;
    logic [24:0] mod_now;
    seq_kind_t   seq_kind;
    int          seq_step;
    int          walk_max;
    longint      walk_pos;

    ssg_sample_if sample_ch ();
    ssg_result_if result_ch ();
    ssg_cfg_if    cfg_ch ();

    spindle_synced_step_generator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    step_gen_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Next encoder count: walks, wrap ratchets, with occasional noise.
    function automatic logic [23:0] next_count();
        longint      span;
        longint      p;
        logic [24:0] half;
        logic [23:0] cnt;
        span = (mod_now < 2 || mod_now > MOD_FULL) ? longint'(MOD_FULL) : longint'(mod_now);
        half = mod_now >> 1;
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        case (seq_kind)
            SEQ_WALK_FWD, SEQ_WALK_BACK:
            begin
                p = longint'($urandom_range(0, walk_max));
                p = (seq_kind == SEQ_WALK_FWD) ? walk_pos + p : walk_pos - p;
                p = p % span;
                if (p < 0)
                    p = p + span;
                walk_pos = p;
                cnt = 24'(p);
            end
            SEQ_RATCHET_UP, SEQ_RATCHET_DOWN:
            begin
                // Up by more than half, back by exactly half: every other sample wraps.
                p = longint'(seq_step / 2);
                if (seq_step % 2 != 0)
                    p = p + longint'(half) + 1;
                seq_step++;
                cnt = (seq_kind == SEQ_RATCHET_UP) ? 24'(p) : 24'hFF_FFFF - 24'(p);
            end
            default:
                cnt = 24'($urandom);
        endcase
        return cnt;
    endfunction

    // One sample transfer; valid stays high for a following item.
    task automatic send_count(input logic [23:0] cnt);
        sample_ch.valid         <= 1'b1;
        sample_ch.encoder_count <= cnt;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    // A run of samples in bursts with random gaps, or with no gaps at all.
    task automatic run_stream(input int n);
        int left;
        int burst;
        int gap;
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        left   = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0)
            begin
                send_count(next_count());
                burst--;
                left--;
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (left > 0 && gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One register write transfer; valid is left high for a following write.
    task automatic write_reg(input cfg_index_t idx, input logic [27:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Writes all four registers back to back while the block is idle.
    task automatic apply_settings(input logic [27:0] ratio, input bit rev, input bit en,
                                  input logic [24:0] modulus);
        write_reg(CFG_FEED_RATIO, ratio);
        write_reg(CFG_FEED_REVERSE, 28'(rev));
        write_reg(CFG_DRIVE_ENABLE, 28'(en));
        write_reg(CFG_ENCODER_MODULUS, 28'(modulus));
        cfg_ch.valid <= 1'b0;
        ratio_now = ratio;
        mod_now   = modulus;
        seq_step  = 0;
    endtask

    // Result side stalls in four modes in turn: always ready, random, a fixed pattern, a repeating window.
    initial
    begin
        int unsigned cyc;
        logic [15:0] pattern;
        cyc     = 0;
        pattern = 16'b1101_1110_0110_1011;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            case ((cyc / 150) % 4)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= pattern[cyc[3:0]];
                default: result_ch.ready <= ((cyc % 24) >= 10);
            endcase
        end
    end

    // Run limit.
    initial
    begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int          done_items;
        int          n;
        logic [27:0] ratio;
        logic [24:0] modulus;

        rst_n                   <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.encoder_count <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_FEED_RATIO;
        cfg_ch.data             <= '0;
        ratio_now  = RATIO_ONE;
        mod_now    = MOD_FULL;
        seq_kind   = SEQ_WALK_FWD;
        seq_step   = 0;
        walk_max   = 64;
        walk_pos   = 0;
        done_items = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: first tick resyncs, then full-range jumps both ways.
        send_count(24'h00_0000);
        send_count(24'hFF_FFFF);
        send_count(24'h00_0000);
        send_count(24'h00_0001);
        send_count(24'h80_0001);
        send_count(24'h5A_5A5A);
        settle();

        // Zero ratio, drive off, zero modulus: any count change is a wrap.
        apply_settings(28'h0, 1'b0, 1'b0, 25'd0);
        send_count(24'h00_0005);
        send_count(24'h00_0005);
        send_count(24'hAA_AAAA);
        settle();

        // Largest ratio, reversed, modulus of one.
        apply_settings(RATIO_MAX, 1'b1, 1'b1, 25'd1);
        send_count(24'hFF_FFFF);
        send_count(24'h00_0000);
        send_count(24'h00_0001);
        send_count(24'h00_0001);
        settle();

        // Drive off with the smallest legal modulus.
        apply_settings(RATIO_ONE, 1'b0, 1'b0, 25'd2);
        send_count(24'h00_0002);
        send_count(24'h00_0000);
        send_count(24'h00_0001);
        settle();

        // Half ratio, modulus of three, wraps around a tiny counter.
        apply_settings(28'h080_0000, 1'b0, 1'b1, 25'd3);
        send_count(24'h00_0000);
        send_count(24'h00_0002);
        send_count(24'h00_0000);
        send_count(24'h00_0001);
        send_count(24'h00_0002);
        settle();

        // Repeated wraps at the largest ratio push the motor position past 32 bits.
        apply_settings(RATIO_MAX, 1'b0, 1'b1, MOD_FULL);
        seq_kind = SEQ_RATCHET_UP;
        run_stream(40);
        settle();
        done_items = 40;

        // Random phases, each with fresh settings and a sequence shape.
        while (done_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       ratio = 28'h0;
                1:       ratio = RATIO_MAX;
                2:       ratio = RATIO_ONE;
                3:       ratio = ratio_now;
                4:       ratio = 28'($urandom);
                default: ratio = 28'($urandom_range(1, 32'h200_0000));
            endcase
            case ($urandom_range(0, 7))
                0:       modulus = 25'd2;
                1:       modulus = 25'd3;
                2:       modulus = 25'($urandom_range(0, 1));
                3, 4:    modulus = MOD_FULL;
                5:       modulus = 25'd1 << $urandom_range(1, 24);
                default: modulus = 25'($urandom_range(2, 32'h100_0000));
            endcase
            case ($urandom_range(0, 9))
                0, 1:    seq_kind = SEQ_WALK_FWD;
                2, 3:    seq_kind = SEQ_WALK_BACK;
                4, 5:    seq_kind = SEQ_RATCHET_UP;
                6, 7:    seq_kind = SEQ_RATCHET_DOWN;
                default: seq_kind = SEQ_NOISE;
            endcase
            case ($urandom_range(0, 3))
                0:       walk_max = 1;
                1:       walk_max = 64;
                2:       walk_max = 4096;
                default: walk_max = 1 << 20;
            endcase
            apply_settings(ratio, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0),
                           modulus);
            n = $urandom_range(30, 70);
            if ($urandom_range(0, 3) == 0)
            begin
                // Pause mid-phase until the block has drained.
                run_stream(n / 2);
                settle();
                run_stream(n - n / 2);
            end
            else
            begin
                run_stream(n);
            end
            settle();
            done_items += n;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
